// ===== hw/rtl/ppc_pkg.sv =====
package ppc_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIVIDE,
    ST_FINISH
  } ppc_state_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [VALUE_WIDTH-1:0] divisor;
  } ppc_div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] rem;
  } ppc_div_rsp_t;

endpackage

// ===== hw/rtl/parity_and_prime_classifier.sv =====
// Sequencing: negative values, values below four and even values go from idle straight to the
// finish state, then the output register; odd values of five and above pass the start and divide
// states once per odd trial divisor from three upward, at most about half the value's square root.
// Throughput: one request at a time; the sequencer takes input only while idle, so the next request is
// taken once the previous result has moved into the output register.
// Reset: synchronous, active low; clears the sequencer, the divider and the output valid flag.
module parity_and_prime_classifier import ppc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_is_even,
  output logic                          out_is_prime
);

  ppc_state_t             state_r;
  ppc_state_t             state_nxt;
  logic [VALUE_WIDTH-1:0] n_r;
  logic [VALUE_WIDTH-1:0] d_r;
  logic                   even_r;
  logic                   prime_r;
  logic                   out_valid_r;
  logic                   out_even_r;
  logic                   out_prime_r;

  ppc_div_req_t div_req;
  ppc_div_rsp_t div_rsp;

  logic in_acc;
  logic in_neg;
  logic in_lt4;
  logic in_lt2;
  logic in_hard;
  logic past_root;
  logic has_factor;
  logic out_free;
  logic load_out;

  ppc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    in_neg     = in_value[VALUE_WIDTH-1];
    in_lt4     = ~in_neg && (in_value[VALUE_WIDTH-2:2] == '0);
    in_lt2     = in_lt4 && ~in_value[1];
    // Only odd values of five and above need trial division.
    in_hard    = ~in_neg && ~in_lt4 && in_value[0];
    // Once the divisor exceeds the quotient its square exceeds the value.
    past_root  = d_r > div_rsp.quot;
    has_factor = div_rsp.rem == '0;
    out_free   = ~out_valid_r || ~out_stall;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_hard ? ST_START : ST_FINISH;
        end
      end
      ST_START: begin
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_rsp.done) begin
          state_nxt = (past_root || has_factor) ? ST_FINISH : ST_START;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = n_r;
    div_req.divisor  = d_r;
    case (state_r)
      ST_IDLE:   in_stall      = 1'b0;
      ST_START:  div_req.start = 1'b1;
      ST_DIVIDE: ;
      ST_FINISH: load_out      = out_free;
      default:   ;
    endcase
    in_acc = in_valid && ~in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r     <= in_value;
      d_r     <= VALUE_WIDTH'(3);
      even_r  <= ~in_value[0];
      prime_r <= in_lt4 && ~in_lt2;
    end else if (state_r == ST_DIVIDE && div_rsp.done) begin
      if (past_root) begin
        prime_r <= 1'b1;
      end else if (has_factor) begin
        prime_r <= 1'b0;
      end else begin
        d_r <= d_r + VALUE_WIDTH'(2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_even_r  <= even_r;
      out_prime_r <= prime_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_is_even  = out_even_r;
  assign out_is_prime = out_prime_r;

endmodule

// ===== hw/rtl/ppc_div.sv =====
module ppc_div import ppc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  ppc_div_req_t req,
  output ppc_div_rsp_t rsp
);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [VALUE_WIDTH-1:0] rem_r;
  logic [VALUE_WIDTH-1:0] quo_r;
  logic [VALUE_WIDTH-1:0] div_r;

  logic [VALUE_WIDTH:0]   rem_sh;
  logic [VALUE_WIDTH:0]   diff;
  logic                   fits;
  logic [VALUE_WIDTH-1:0] rem_nxt;
  logic [VALUE_WIDTH-1:0] quo_nxt;

  // One quotient bit per cycle: shift in the next dividend bit and try a subtraction.
  always_comb begin
    rem_sh  = {rem_r, quo_r[VALUE_WIDTH-1]};
    diff    = rem_sh - {1'b0, div_r};
    fits    = ~diff[VALUE_WIDTH];
    rem_nxt = fits ? diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
    quo_nxt = {quo_r[VALUE_WIDTH-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(VALUE_WIDTH - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
